@@ rtl/mqfm_pkg.sv @@
// Package: operation and status codes, field widths and the result record.
`timescale 1ns / 1ps

package mqfm_pkg;

  localparam int OP_W     = 3;
  localparam int SEL_W    = 4;
  localparam int DATA_W   = 32;
  localparam int CAP_W    = 12;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 11;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_PUSH    = 3'd2,
    OP_POP     = 3'd3,
    OP_DROP    = 3'd4,
    OP_CLEAN   = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_ID    = 3'd3,
    ST_NOT_OPEN  = 3'd4,
    ST_NONE_FREE = 3'd5
  } status_t;

  typedef struct packed {
    logic              done;
    status_t           status;
    logic [SEL_W-1:0]  queue;
    logic [FILL_W-1:0] fill;
    logic              pop;
  } result_t;

endpackage

@@ rtl/multi_queue_fifo_manager.sv @@
// Top level: multi-queue FIFO manager over a shared payload store.
//
// Requests enter on start with operation, queue_sel, write_data and capacity.
// A request is taken at a rising edge where start is high and busy is low.
// Create claims the lowest free queue; destroy, push, pop, drop and clean
// act on queue_sel. Every request yields exactly one result.
// The result (status, read_data, result_queue, fill_level) is presented for
// one cycle with done high, in the cycle right after the request is taken.
// Throughput: one request per cycle while busy is low, back to back, since
// each request updates one queue descriptor and touches one store word; the
// popped word comes from the store's registered read port.
// The receiver cannot stall; results are never held and never dropped.
// Reset (rst, synchronous) closes every queue and clears all pointers and
// counts; busy is high during reset and the cycle after. The store is not
// cleared: a pop only reads words written by an earlier push.
`timescale 1ns / 1ps

module multi_queue_fifo_manager #(
  parameter int NUM_QUEUES    = 8,
  parameter int MAX_DEPTH     = 1024,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [mqfm_pkg::OP_W-1:0]        operation,
  input  logic [mqfm_pkg::SEL_W-1:0]       queue_sel,
  input  logic [mqfm_pkg::DATA_W-1:0]      write_data,
  input  logic [mqfm_pkg::CAP_W-1:0]       capacity,
  output logic                             done,
  output logic [mqfm_pkg::STATUS_W-1:0]    status,
  output logic [mqfm_pkg::DATA_W-1:0]      read_data,
  output logic [mqfm_pkg::SEL_W-1:0]       result_queue,
  output logic [mqfm_pkg::FILL_W-1:0]      fill_level
);

  localparam int AW = $clog2(NUM_QUEUES * MAX_DEPTH);
  localparam int XW = (PAYLOAD_WIDTH > mqfm_pkg::DATA_W) ? PAYLOAD_WIDTH : mqfm_pkg::DATA_W;

  logic                     accept;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [PAYLOAD_WIDTH-1:0] mem_rdata;
  logic [XW-1:0]            wr_wide;
  logic [XW-1:0]            rd_wide;
  mqfm_pkg::result_t        res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept  = start & ~busy;
  assign wr_wide = XW'(write_data);
  assign rd_wide = XW'(mem_rdata);

  mqfm_ctrl #(
    .NUM_QUEUES (NUM_QUEUES),
    .MAX_DEPTH  (MAX_DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .queue_sel (queue_sel),
    .capacity  (capacity),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  mqfm_store #(
    .AW (AW),
    .DW (PAYLOAD_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_wide[PAYLOAD_WIDTH-1:0]),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign done         = res.done;
  assign status       = res.status;
  assign result_queue = res.queue;
  assign fill_level   = res.fill;
  assign read_data    = res.pop ? rd_wide[mqfm_pkg::DATA_W-1:0] : '0;

endmodule

@@ rtl/mqfm_store.sv @@
// Shared payload store: one write port, one registered read port.
`timescale 1ns / 1ps

module mqfm_store #(
  parameter int AW = 13,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(2**AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mqfm_ctrl.sv @@
// Queue descriptor table, request decode and result register.
`timescale 1ns / 1ps

module mqfm_ctrl #(
  parameter int NUM_QUEUES = 8,
  parameter int MAX_DEPTH  = 1024,
  parameter int AW         = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [mqfm_pkg::OP_W-1:0]     operation,
  input  logic [mqfm_pkg::SEL_W-1:0]    queue_sel,
  input  logic [mqfm_pkg::CAP_W-1:0]    capacity,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  output mqfm_pkg::result_t             res
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(MAX_DEPTH);
  localparam int CW = $clog2(MAX_DEPTH + 1);

  logic          open_q [0:NUM_QUEUES-1];
  logic [CW-1:0] cap_q  [0:NUM_QUEUES-1];
  logic [PW-1:0] head_q [0:NUM_QUEUES-1];
  logic [PW-1:0] tail_q [0:NUM_QUEUES-1];
  logic [CW-1:0] cnt_q  [0:NUM_QUEUES-1];

  mqfm_pkg::op_t     op;
  mqfm_pkg::status_t st_next;
  logic                       sel_ok;
  logic [QW-1:0]              sel_idx;
  logic                       sel_open;
  logic [CW-1:0]              sel_cap;
  logic [PW-1:0]              sel_head;
  logic [PW-1:0]              sel_tail;
  logic [CW-1:0]              sel_cnt;
  logic [CW-1:0]              head_inc;
  logic [CW-1:0]              tail_inc;
  logic [PW-1:0]              head_adv;
  logic [PW-1:0]              tail_adv;
  logic                       free_found;
  logic [QW-1:0]              free_idx;
  logic [CW-1:0]              cap_clamp;
  logic [mqfm_pkg::SEL_W-1:0] rq_next;
  logic [CW-1:0]              fill_next;
  logic                       pop_next;
  logic                       we_next;
  logic                       re_next;
  logic                       upd_en;
  logic [QW-1:0]              upd_idx;
  logic                       open_n;
  logic [CW-1:0]              cap_n;
  logic [PW-1:0]              head_n;
  logic [PW-1:0]              tail_n;
  logic [CW-1:0]              cnt_n;

  assign op      = mqfm_pkg::op_t'(operation);
  assign sel_ok  = {1'b0, queue_sel} < (mqfm_pkg::SEL_W + 1)'(NUM_QUEUES);
  assign sel_idx = QW'(queue_sel);

  assign sel_open = open_q[sel_idx];
  assign sel_cap  = cap_q[sel_idx];
  assign sel_head = head_q[sel_idx];
  assign sel_tail = tail_q[sel_idx];
  assign sel_cnt  = cnt_q[sel_idx];

  assign head_inc = CW'(sel_head) + CW'(1);
  assign tail_inc = CW'(sel_tail) + CW'(1);
  assign head_adv = (head_inc >= sel_cap) ? '0 : head_inc[PW-1:0];
  assign tail_adv = (tail_inc >= sel_cap) ? '0 : tail_inc[PW-1:0];

  assign cap_clamp = ({1'b0, capacity} > (mqfm_pkg::CAP_W + 1)'(MAX_DEPTH)) ?
                     CW'(MAX_DEPTH) : CW'(capacity);

  assign mem_waddr = AW'(sel_idx) * AW'(MAX_DEPTH) + AW'(sel_tail);
  assign mem_raddr = AW'(sel_idx) * AW'(MAX_DEPTH) + AW'(sel_head);
  assign mem_we    = accept & we_next;
  assign mem_re    = accept & re_next;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
      if (!open_q[q]) begin
        free_found = 1'b1;
        free_idx   = QW'(q);
      end
    end
  end

  always_comb begin
    st_next   = mqfm_pkg::ST_OK;
    rq_next   = queue_sel;
    fill_next = '0;
    pop_next  = 1'b0;
    we_next   = 1'b0;
    re_next   = 1'b0;
    upd_en    = 1'b0;
    upd_idx   = sel_idx;
    open_n    = sel_open;
    cap_n     = sel_cap;
    head_n    = sel_head;
    tail_n    = sel_tail;
    cnt_n     = sel_cnt;
    unique case (op) inside
      mqfm_pkg::OP_CREATE: begin
        rq_next = '0;
        if (!free_found) begin
          st_next = mqfm_pkg::ST_NONE_FREE;
        end else if (capacity == '0) begin
          st_next = mqfm_pkg::ST_BAD_ID;
        end else begin
          upd_en  = 1'b1;
          upd_idx = free_idx;
          open_n  = 1'b1;
          cap_n   = cap_clamp;
          head_n  = '0;
          tail_n  = '0;
          cnt_n   = '0;
          rq_next = mqfm_pkg::SEL_W'(free_idx);
        end
      end
      mqfm_pkg::OP_DESTROY, mqfm_pkg::OP_PUSH, mqfm_pkg::OP_POP,
      mqfm_pkg::OP_DROP, mqfm_pkg::OP_CLEAN: begin
        if (!sel_ok) begin
          st_next = mqfm_pkg::ST_BAD_ID;
        end else if (!sel_open) begin
          st_next = mqfm_pkg::ST_NOT_OPEN;
        end else begin
          unique case (op) inside
            mqfm_pkg::OP_DESTROY: begin
              upd_en = 1'b1;
              open_n = 1'b0;
              head_n = '0;
              tail_n = '0;
              cnt_n  = '0;
            end
            mqfm_pkg::OP_PUSH: begin
              if (sel_cnt >= sel_cap) begin
                st_next   = mqfm_pkg::ST_FULL;
                fill_next = sel_cnt;
              end else begin
                we_next   = 1'b1;
                upd_en    = 1'b1;
                tail_n    = tail_adv;
                cnt_n     = sel_cnt + CW'(1);
                fill_next = sel_cnt + CW'(1);
              end
            end
            mqfm_pkg::OP_POP, mqfm_pkg::OP_DROP: begin
              if (sel_cnt == '0) begin
                st_next = mqfm_pkg::ST_EMPTY;
              end else begin
                upd_en    = 1'b1;
                head_n    = head_adv;
                cnt_n     = sel_cnt - CW'(1);
                fill_next = sel_cnt - CW'(1);
                re_next   = (op == mqfm_pkg::OP_POP);
                pop_next  = (op == mqfm_pkg::OP_POP);
              end
            end
            mqfm_pkg::OP_CLEAN: begin
              upd_en = 1'b1;
              head_n = sel_tail;
              cnt_n  = '0;
            end
            default: begin
              st_next = mqfm_pkg::ST_BAD_ID;
            end
          endcase
        end
      end
      default: begin
        st_next = mqfm_pkg::ST_BAD_ID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        open_q[q] <= 1'b0;
        cap_q[q]  <= '0;
        head_q[q] <= '0;
        tail_q[q] <= '0;
        cnt_q[q]  <= '0;
      end
    end else if (accept && upd_en) begin
      open_q[upd_idx] <= open_n;
      cap_q[upd_idx]  <= cap_n;
      head_q[upd_idx] <= head_n;
      tail_q[upd_idx] <= tail_n;
      cnt_q[upd_idx]  <= cnt_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.done <= 1'b0;
    end else begin
      res.done <= accept;
    end
    if (accept) begin
      res.status <= st_next;
      res.queue  <= rq_next;
      res.fill   <= mqfm_pkg::FILL_W'(fill_next);
      res.pop    <= pop_next;
    end
  end

`ifndef SYNTH
  for (genvar gq = 0; gq < NUM_QUEUES; gq++) begin : g_chk
    a_cnt_cap : assert property (@(posedge clk) disable iff (rst)
      cnt_q[gq] <= cap_q[gq])
      else $error("queue count above its capacity");
    a_closed_idle : assert property (@(posedge clk) disable iff (rst)
      !open_q[gq] |-> (cnt_q[gq] == '0 && head_q[gq] == '0 && tail_q[gq] == '0))
      else $error("closed queue holds entries or pointers");
    a_ptr_range : assert property (@(posedge clk) disable iff (rst)
      open_q[gq] |-> (CW'(head_q[gq]) < cap_q[gq] && CW'(tail_q[gq]) < cap_q[gq]))
      else $error("queue pointer outside its ring");
  end

  a_one_port : assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("store written and read by one request");

  a_pop_ok : assert property (@(posedge clk) disable iff (rst)
    mem_re |=> (res.done && res.pop && res.status == mqfm_pkg::ST_OK))
    else $error("store read without a successful pop result");
`endif

endmodule

@@ dv/testbench.sv @@
// Testbench: random and directed request streams for the multi-queue FIFO manager, self-checked.
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_QUEUES     = 8;
  localparam int MAX_DEPTH      = 1024;
  localparam int PAYLOAD_WIDTH  = 32;
  localparam int PTR_W          = $clog2(MAX_DEPTH);
  localparam int RANDOM_OPS     = 950;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [mqfm_pkg::OP_W-1:0] OP_RESERVED_A = 3'd6;
  localparam logic [mqfm_pkg::OP_W-1:0] OP_RESERVED_B = 3'd7;

  typedef struct {
    logic [mqfm_pkg::OP_W-1:0]   op;
    logic [mqfm_pkg::SEL_W-1:0]  sel;
    logic [mqfm_pkg::DATA_W-1:0] data;
    logic [mqfm_pkg::CAP_W-1:0]  cap;
    int unsigned                 gap;
  } queue_op_t;

  typedef struct {
    mqfm_pkg::status_t           status;
    logic [mqfm_pkg::DATA_W-1:0] data;
    logic [mqfm_pkg::SEL_W-1:0]  queue;
    logic [mqfm_pkg::FILL_W-1:0] fill;
  } op_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [mqfm_pkg::OP_W-1:0]     operation = '0;
  logic [mqfm_pkg::SEL_W-1:0]    queue_sel = '0;
  logic [mqfm_pkg::DATA_W-1:0]   write_data = '0;
  logic [mqfm_pkg::CAP_W-1:0]    capacity = '0;
  logic                          busy;
  logic                          done;
  logic [mqfm_pkg::STATUS_W-1:0] status;
  logic [mqfm_pkg::DATA_W-1:0]   read_data;
  logic [mqfm_pkg::SEL_W-1:0]    result_queue;
  logic [mqfm_pkg::FILL_W-1:0]   fill_level;

  queue_op_t  pending_ops[$];
  op_result_t awaited_results[$];
  queue_op_t  in_flight;
  int unsigned idle_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;

  // predicted queue state
  logic                        q_open  [NUM_QUEUES];
  logic [mqfm_pkg::FILL_W-1:0] q_cap   [NUM_QUEUES];
  logic [PTR_W-1:0]            q_head  [NUM_QUEUES];
  logic [PTR_W-1:0]            q_tail  [NUM_QUEUES];
  logic [mqfm_pkg::FILL_W-1:0] q_count [NUM_QUEUES];
  logic [mqfm_pkg::DATA_W-1:0] q_ring  [NUM_QUEUES][MAX_DEPTH];

  // which queues the request stream expects to be open
  logic plan_open [NUM_QUEUES];

  multi_queue_fifo_manager #(
    .NUM_QUEUES   (NUM_QUEUES),
    .MAX_DEPTH    (MAX_DEPTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .queue_sel   (queue_sel),
    .write_data  (write_data),
    .capacity    (capacity),
    .done        (done),
    .status      (status),
    .read_data   (read_data),
    .result_queue(result_queue),
    .fill_level  (fill_level)
  );

  always #5 clk = ~clk;

  function automatic logic [PTR_W-1:0] ring_next(int s, logic [PTR_W-1:0] p);
    logic [mqfm_pkg::FILL_W-1:0] n;
    n = mqfm_pkg::FILL_W'(p) + 1'b1;
    return (n >= q_cap[s]) ? '0 : n[PTR_W-1:0];
  endfunction

  function automatic op_result_t run_queue_op(queue_op_t r);
    op_result_t res;
    int q;
    int s;
    res.status = mqfm_pkg::ST_OK;
    res.data   = '0;
    res.queue  = r.sel;
    res.fill   = '0;
    s = int'(r.sel);
    if (r.op == mqfm_pkg::OP_CREATE) begin
      res.queue = '0;
      q = 0;
      while (q < NUM_QUEUES && q_open[q]) q++;
      if (q >= NUM_QUEUES) begin
        res.status = mqfm_pkg::ST_NONE_FREE;
      end else if (r.cap == 0) begin
        res.status = mqfm_pkg::ST_BAD_ID;
      end else begin
        q_open[q]  = 1'b1;
        q_cap[q]   = (r.cap > MAX_DEPTH) ? mqfm_pkg::FILL_W'(MAX_DEPTH) :
                                           mqfm_pkg::FILL_W'(r.cap);
        q_head[q]  = '0;
        q_tail[q]  = '0;
        q_count[q] = '0;
        res.queue  = mqfm_pkg::SEL_W'(q);
      end
    end else if (r.op > mqfm_pkg::OP_CLEAN || s >= NUM_QUEUES) begin
      res.status = mqfm_pkg::ST_BAD_ID;
    end else if (!q_open[s]) begin
      res.status = mqfm_pkg::ST_NOT_OPEN;
    end else begin
      case (r.op) inside
        mqfm_pkg::OP_DESTROY: begin
          q_open[s]  = 1'b0;
          q_head[s]  = '0;
          q_tail[s]  = '0;
          q_count[s] = '0;
        end
        mqfm_pkg::OP_PUSH: begin
          if (q_count[s] >= q_cap[s]) begin
            res.status = mqfm_pkg::ST_FULL;
          end else begin
            q_ring[s][q_tail[s]] = r.data;
            q_tail[s]  = ring_next(s, q_tail[s]);
            q_count[s] = q_count[s] + 1'b1;
          end
          res.fill = q_count[s];
        end
        mqfm_pkg::OP_POP, mqfm_pkg::OP_DROP: begin
          if (q_count[s] == 0) begin
            res.status = mqfm_pkg::ST_EMPTY;
          end else begin
            if (r.op == mqfm_pkg::OP_POP) res.data = q_ring[s][q_head[s]];
            q_head[s]  = ring_next(s, q_head[s]);
            q_count[s] = q_count[s] - 1'b1;
          end
          res.fill = q_count[s];
        end
        default: begin
          q_head[s]  = q_tail[s];
          q_count[s] = '0;
        end
      endcase
    end
    return res;
  endfunction

  function automatic int unsigned next_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 58) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic enqueue_op(logic [mqfm_pkg::OP_W-1:0] op, logic [mqfm_pkg::SEL_W-1:0] sel,
                            logic [mqfm_pkg::DATA_W-1:0] data,
                            logic [mqfm_pkg::CAP_W-1:0] cap);
    queue_op_t r;
    int q;
    r.op   = op;
    r.sel  = sel;
    r.data = data;
    r.cap  = cap;
    r.gap  = next_gap();
    if (op == mqfm_pkg::OP_CREATE) begin
      q = 0;
      while (q < NUM_QUEUES && plan_open[q]) q++;
      if (q < NUM_QUEUES && cap != 0) plan_open[q] = 1'b1;
    end else if (op == mqfm_pkg::OP_DESTROY && int'(sel) < NUM_QUEUES) begin
      plan_open[sel] = 1'b0;
    end
    pending_ops.push_back(r);
  endtask

  function automatic logic [mqfm_pkg::SEL_W-1:0] pick_target();
    int open_ids[$];
    for (int q = 0; q < NUM_QUEUES; q++) if (plan_open[q]) open_ids.push_back(q);
    if (open_ids.size() == 0 || $urandom_range(0, 9) == 0)
      return mqfm_pkg::SEL_W'($urandom_range(0, 15));
    return mqfm_pkg::SEL_W'(open_ids[$urandom_range(0, open_ids.size() - 1)]);
  endfunction

  function automatic logic [mqfm_pkg::CAP_W-1:0] pick_capacity();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return mqfm_pkg::CAP_W'($urandom_range(1, 8));
    if (r < 78) return '0;
    if (r < 88) return mqfm_pkg::CAP_W'($urandom_range(MAX_DEPTH + 1, 4095));
    return mqfm_pkg::CAP_W'($urandom_range(1, 4095));
  endfunction

  function automatic logic [mqfm_pkg::DATA_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic plan_random_op();
    int unsigned r;
    int open_cnt;
    open_cnt = 0;
    for (int q = 0; q < NUM_QUEUES; q++) if (plan_open[q]) open_cnt++;
    r = $urandom_range(0, 99);
    if (open_cnt == 0 || r < 6)
      enqueue_op(mqfm_pkg::OP_CREATE, mqfm_pkg::SEL_W'($urandom_range(0, 15)),
                 pick_word(), pick_capacity());
    else if (r < 11)
      enqueue_op(mqfm_pkg::OP_DESTROY, pick_target(), pick_word(),
                 mqfm_pkg::CAP_W'($urandom));
    else if (r < 50)
      enqueue_op(mqfm_pkg::OP_PUSH, pick_target(), pick_word(), mqfm_pkg::CAP_W'($urandom));
    else if (r < 82)
      enqueue_op(mqfm_pkg::OP_POP, pick_target(), pick_word(), mqfm_pkg::CAP_W'($urandom));
    else if (r < 91)
      enqueue_op(mqfm_pkg::OP_DROP, pick_target(), pick_word(), mqfm_pkg::CAP_W'($urandom));
    else if (r < 95)
      enqueue_op(mqfm_pkg::OP_CLEAN, pick_target(), pick_word(), mqfm_pkg::CAP_W'($urandom));
    else
      enqueue_op(mqfm_pkg::OP_W'($urandom_range(0, 7)),
                 mqfm_pkg::SEL_W'($urandom_range(0, 15)),
                 pick_word(), mqfm_pkg::CAP_W'($urandom));
  endtask

  task automatic present(queue_op_t r);
    in_flight = r;
    start      <= 1'b1;
    operation  <= r.op;
    queue_sel  <= r.sel;
    write_data <= r.data;
    capacity   <= r.cap;
  endtask

  task automatic note_mismatch(string what);
    if (mismatches < 200) $display("%0t: result %0d: %s", $time, results_seen, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else if (start && !busy) begin
      awaited_results.push_back(run_queue_op(in_flight));
      if (pending_ops.size() != 0 && pending_ops[0].gap == 0) begin
        present(pending_ops.pop_front());
      end else begin
        start      <= 1'b0;
        idle_left  <= (pending_ops.size() != 0) ? pending_ops[0].gap - 1 : 0;
        operation  <= mqfm_pkg::OP_W'($urandom);
        queue_sel  <= mqfm_pkg::SEL_W'($urandom);
        write_data <= $urandom;
        capacity   <= mqfm_pkg::CAP_W'($urandom);
      end
    end else if (!start && pending_ops.size() != 0) begin
      if (idle_left == 0) present(pending_ops.pop_front());
      else idle_left <= idle_left - 1;
    end
  end

  always @(posedge clk) begin : check_results
    op_result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("result with no request outstanding");
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (read_data !== want.data)
          note_mismatch($sformatf("read_data %h, want %h", read_data, want.data));
        if (result_queue !== want.queue)
          note_mismatch($sformatf("result_queue %0d, want %0d", result_queue, want.queue));
        if (fill_level !== want.fill)
          note_mismatch($sformatf("fill_level %0d, want %0d", fill_level, want.fill));
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      q_open[q]    = 1'b0;
      q_cap[q]     = '0;
      q_head[q]    = '0;
      q_tail[q]    = '0;
      q_count[q]   = '0;
      plan_open[q] = 1'b0;
    end

    enqueue_op(mqfm_pkg::OP_POP, 4'd0, '0, '0);
    enqueue_op(mqfm_pkg::OP_PUSH, 4'd15, '1, '1);
    enqueue_op(OP_RESERVED_A, 4'd2, '1, '1);
    enqueue_op(mqfm_pkg::OP_CREATE, 4'd0, '0, '0);
    enqueue_op(mqfm_pkg::OP_CREATE, 4'd9, '0, 12'd1);
    enqueue_op(mqfm_pkg::OP_PUSH, 4'd0, '1, '0);
    enqueue_op(mqfm_pkg::OP_PUSH, 4'd0, '0, '0);
    enqueue_op(mqfm_pkg::OP_POP, 4'd0, '0, '0);
    enqueue_op(mqfm_pkg::OP_POP, 4'd0, '0, '0);
    enqueue_op(mqfm_pkg::OP_DROP, 4'd0, '0, '0);
    enqueue_op(mqfm_pkg::OP_CREATE, 4'd0, '0, '1);
    enqueue_op(mqfm_pkg::OP_PUSH, 4'd1, 32'hA5A5_A5A5, '0);
    enqueue_op(mqfm_pkg::OP_PUSH, 4'd1, 32'h5A5A_5A5A, '0);
    enqueue_op(mqfm_pkg::OP_PUSH, 4'd1, 32'h0123_4567, '0);
    enqueue_op(mqfm_pkg::OP_DROP, 4'd1, '0, '0);
    enqueue_op(mqfm_pkg::OP_POP, 4'd1, '0, '0);
    enqueue_op(mqfm_pkg::OP_CLEAN, 4'd1, '0, '0);
    enqueue_op(mqfm_pkg::OP_POP, 4'd1, '0, '0);
    enqueue_op(mqfm_pkg::OP_CREATE, 4'd0, '0, 12'd1024);
    for (int q = 3; q < NUM_QUEUES; q++) enqueue_op(mqfm_pkg::OP_CREATE, 4'd0, '0, 12'd2);
    enqueue_op(mqfm_pkg::OP_CREATE, 4'd0, '0, 12'd5);
    enqueue_op(mqfm_pkg::OP_DESTROY, 4'd0, '0, '0);
    enqueue_op(OP_RESERVED_B, 4'd0, '0, '0);
    repeat (RANDOM_OPS) plan_random_op();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (!(pending_ops.size() == 0 && !start && awaited_results.size() == 0)
           && idle_cycles < WATCHDOG_LIMIT)
      @(negedge clk);
    if (idle_cycles < WATCHDOG_LIMIT) begin
      repeat (4) @(negedge clk);
      if (awaited_results.size() != 0)
        note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    end
    if (idle_cycles < WATCHDOG_LIMIT && mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
rtl/mqfm_pkg.sv
rtl/mqfm_store.sv
rtl/mqfm_ctrl.sv
rtl/multi_queue_fifo_manager.sv
dv/testbench.sv
